@@ sv/pfi_pkg.sv @@
// Package with the request and result types and the codes of the palette frame interpolator.
package pfi_pkg;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_PAL_WR = 1'b1;

	localparam logic [1:0] PHASE_QUARTER = 2'd0;
	localparam logic [1:0] PHASE_HALF = 2'd1;
	localparam logic [1:0] PHASE_THREE_Q = 2'd2;
	localparam logic [1:0] PHASE_KEY = 2'd3;

	typedef struct packed {
		logic        op;
		logic [7:0]  pixel_index;
		logic [16:0] pixel_position;
		logic [31:0] palette_value;
	} in_req_t;

	typedef struct packed {
		logic [7:0] out_byte0;
		logic [7:0] out_byte1;
		logic [7:0] out_byte2;
		logic [7:0] out_byte3;
		logic       top_written;
	} out_res_t;

endpackage

@@ sv/pfi_in_if.sv @@
// Handshake interface for the pixel and palette request channel.
interface pfi_in_if;
	logic            valid;
	logic            ready;
	pfi_pkg::in_req_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

@@ sv/pfi_out_if.sv @@
// Handshake interface for the blended colour result channel.
interface pfi_out_if;
	logic              valid;
	logic              ready;
	pfi_pkg::out_res_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

@@ sv/pfi_palette_mem.sv @@
// Palette memory of 256 colour words with a registered read port.
module pfi_palette_mem (
	input  logic        clk,
	input  logic        wr_en,
	input  logic [7:0]  wr_addr,
	input  logic [31:0] wr_data,
	input  logic        rd_en,
	input  logic [7:0]  rd_addr,
	output logic [31:0] rd_data
);

	logic [31:0] mem [256];
	logic [31:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ sv/pfi_key_store.sv @@
// Key-frame store with one colour word for each pixel position and a registered read port.
module pfi_key_store #(
	parameter int DEPTH = 131072,
	parameter int AW = 17
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [31:0]   wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [31:0]   rd_data
);

	logic [31:0] mem [DEPTH];
	logic [31:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ sv/pfi_blend.sv @@
// Blend of the new colour against the key colour for one result.
module pfi_blend (
	input  logic [31:0]       colour,
	input  logic [31:0]       key,
	input  logic [1:0]        phase,
	output pfi_pkg::out_res_t res
);

	function automatic logic [7:0] mix_byte(input logic [7:0] k8, input logic [7:0] c8,
			input logic [1:0] ph);
		logic [9:0] k;
		logic [9:0] c;
		logic [9:0] s;
		logic [7:0] r;
		k = 10'(k8);
		c = 10'(c8);
		case (ph)
			pfi_pkg::PHASE_QUARTER: begin
				s = (k << 1) + k + c;
				r = s[9:2];
			end
			pfi_pkg::PHASE_HALF: begin
				s = k + c;
				r = s[8:1];
			end
			default: begin
				s = k + (c << 1) + c;
				r = s[9:2];
			end
		endcase
		return r;
	endfunction

	always_comb begin
		if (phase == pfi_pkg::PHASE_KEY) begin
			res.out_byte0 = colour[7:0];
			res.out_byte1 = colour[15:8];
			res.out_byte2 = colour[23:16];
			res.out_byte3 = colour[31:24];
			res.top_written = 1'b1;
		end else begin
			res.out_byte0 = mix_byte(key[7:0], colour[7:0], phase);
			res.out_byte1 = mix_byte(key[15:8], colour[15:8], phase);
			res.out_byte2 = mix_byte(key[23:16], colour[23:16], phase);
			res.out_byte3 = 8'd0;
			res.top_written = 1'b0;
		end
	end

endmodule

@@ sv/palette_frame_interpolator_core.sv @@
// Top level of the palette frame interpolator: palette lookup, key-frame store and blend.
//
//   channel   dir  handshake            contents
//   pix_in    in   valid/ready          op, pixel_index, pixel_position, palette_value
//   pix_out   out  valid/ready          out_byte0..3, top_written
//   cfg_wr    in   cfg_wr_en, no wait   blend_phase
//
// One request is taken every cycle while pix_in.ready is high. The palette read and the
// key-frame read are both registered in their memories, and the blend is registered into
// the output stage, so a pixel result passes stage one and then the output register.
// Reset sets blend_phase to the key-frame phase; the memories are not cleared.
// A stalled result holds the output register and the pixel behind it; new requests are
// refused only when both are full and the output is not taken.
module palette_frame_interpolator_core #(
	parameter int MAX_PIXELS = 131072
) (
	input  logic        clk,
	input  logic        arst_n,
	pfi_in_if.sink      pix_in,
	pfi_out_if.source   pix_out,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_wr_data
);

	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int PW = AW + 17;

	logic [1:0]        blend_phase_q;
	logic              valid_s1;
	logic              in_range_s1;
	logic [AW-1:0]     addr_s1;
	logic              out_valid_q;
	pfi_pkg::out_res_t out_q;

	logic              accept_in;
	logic              pix_acc;
	logic              pal_we;
	logic [PW-1:0]     pos_ext;
	logic              in_range;
	logic [AW-1:0]     addr;
	logic              key_phase;
	logic              s1_move;
	logic [31:0]       pal_rdata;
	logic [31:0]       key_rdata;
	logic [31:0]       key_colour;
	pfi_pkg::out_res_t blend_res;

	assign key_phase = (blend_phase_q == pfi_pkg::PHASE_KEY);
	assign s1_move = valid_s1 && (!out_valid_q || pix_out.ready);
	assign pix_in.ready = !valid_s1 || s1_move;
	assign accept_in = pix_in.valid && pix_in.ready;
	assign pix_acc = accept_in && (pix_in.payload.op == pfi_pkg::OP_PIXEL);
	assign pal_we = accept_in && (pix_in.payload.op == pfi_pkg::OP_PAL_WR);
	assign pos_ext = PW'(pix_in.payload.pixel_position);
	assign in_range = pos_ext < PW'(MAX_PIXELS);
	assign addr = pos_ext[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_phase_q <= pfi_pkg::PHASE_KEY;
		end else if (cfg_wr_en) begin
			blend_phase_q <= cfg_wr_data;
		end
	end

	pfi_palette_mem u_palette (
		.clk     (clk),
		.wr_en   (pal_we),
		.wr_addr (pix_in.payload.pixel_index),
		.wr_data (pix_in.payload.palette_value),
		.rd_en   (pix_acc),
		.rd_addr (pix_in.payload.pixel_index),
		.rd_data (pal_rdata)
	);

	pfi_key_store #(
		.DEPTH (MAX_PIXELS),
		.AW    (AW)
	) u_key_store (
		.clk     (clk),
		.wr_en   (s1_move && key_phase && in_range_s1),
		.wr_addr (addr_s1),
		.wr_data (pal_rdata),
		.rd_en   (pix_acc && !key_phase && in_range),
		.rd_addr (addr),
		.rd_data (key_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			in_range_s1 <= in_range;
			addr_s1 <= addr;
		end
	end

	assign key_colour = in_range_s1 ? key_rdata : 32'd0;

	pfi_blend u_blend (
		.colour (pal_rdata),
		.key    (key_colour),
		.phase  (blend_phase_q),
		.res    (blend_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_q <= blend_res;
		end
	end

	assign pix_out.valid = out_valid_q;
	assign pix_out.payload = out_q;

endmodule
